FILE: hdl/lphi_pkg.sv
// Shared types and constants for the linear-probe hash insert block.
// No dependencies; every other file imports this package.
package lphi_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int KEY_WIDTH   = 31;
    localparam int SLOT_W      = $clog2(TABLE_DEPTH);
    localparam int CFG_W       = 11;
    localparam int STATUS_W    = 2;

    // remainder unit: dividend width, bits retired per cycle, chunk counts
    localparam int DIV_W       = 32;
    localparam int DIV_STEP    = 4;
    localparam int HOME_CHUNKS = DIV_W / DIV_STEP;
    localparam int WRAP_CHUNKS = (CFG_W + DIV_STEP - 1) / DIV_STEP;
    localparam int CHUNK_W     = $clog2(HOME_CHUNKS + 1);

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_CLEAR  = 1'b1;

    localparam logic [STATUS_W-1:0] STAT_INSERTED = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_ZERO_KEY = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_CLEARED  = 2'd3;

    localparam logic CFG_TABLE_SIZE   = 1'b0;
    localparam logic CFG_HASH_MODULUS = 1'b1;

    localparam logic [CFG_W-1:0] TABLE_SIZE_RST   = 11'd1024;
    localparam logic [CFG_W-1:0] HASH_MODULUS_RST = 11'd1021;

    typedef struct packed {
        logic                 action;
        logic [KEY_WIDTH-1:0] key_value;
    } in_word_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot_index;
        logic [CFG_W-1:0]    entry_count;
    } out_word_t;

    typedef struct packed {
        logic               start;
        logic [DIV_W-1:0]   dividend;
        logic [CFG_W-1:0]   divisor;
        logic [CHUNK_W-1:0] chunks;
    } div_req_t;

    typedef struct packed {
        logic                 wr_en;
        logic [SLOT_W-1:0]    wr_addr;
        logic [KEY_WIDTH-1:0] wr_data;
        logic                 rd_en;
        logic [SLOT_W-1:0]    rd_addr;
    } ram_req_t;

    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_DIV_HOME,
        ST_DIV_WRAP,
        ST_PROBE,
        ST_RESP
    } state_t;

endpackage

FILE: hdl/lphi_div.sv
// Multi-cycle remainder unit: restoring division, DIV_STEP bits per cycle.
// Depends on lphi_pkg. Only the remainder is kept; the divisor must be nonzero.
module lphi_div (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  lphi_pkg::div_req_t       req,
    output logic                     done,
    output logic [lphi_pkg::CFG_W-1:0] remainder
);
    import lphi_pkg::*;

    logic               busy_reg;
    logic               done_reg;
    logic [CHUNK_W-1:0] cnt_reg;
    logic [DIV_W-1:0]   dvd_reg;
    logic [CFG_W-1:0]   rem_reg;
    logic [CFG_W-1:0]   div_reg;
    logic [CFG_W-1:0]   rem_next;

    always_comb begin
        logic [CFG_W:0] t;
        rem_next = rem_reg;
        t        = '0;
        for (int i = 0; i < DIV_STEP; i++) begin
            t = {rem_next, dvd_reg[DIV_W-1-i]};
            if (t >= {1'b0, div_reg}) begin
                t = t - {1'b0, div_reg};
            end
            rem_next = t[CFG_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.chunks;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CHUNK_W'(1);
                if (cnt_reg == CHUNK_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            dvd_reg <= req.dividend;
            div_reg <= req.divisor;
            rem_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg <= dvd_reg << DIV_STEP;
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

FILE: hdl/lphi_ram.sv
// Slot store: one write port and one read port, read data registered.
// Depends on lphi_pkg for the request struct and sizes.
module lphi_ram (
    input  logic                         aclk,
    input  lphi_pkg::ram_req_t           req,
    output logic [lphi_pkg::KEY_WIDTH-1:0] rd_data
);
    import lphi_pkg::*;

    logic [KEY_WIDTH-1:0] mem [TABLE_DEPTH];
    logic [KEY_WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hdl/linear_probe_hash_insert.sv
// Top level: open-addressing hash insert with linear probing over one slot RAM.
// Depends on lphi_pkg, lphi_div (home slot remainder) and lphi_ram (slot store).
//
//  channel  | handshake           | payload
//  ---------+---------------------+-------------------------------------
//  s_       | s_valid / s_ready   | s_data  : action, key_value
//  m_       | m_valid / m_ready   | m_data  : status, slot_index, entry_count
//  cfg_     | cfg_wr_en           | cfg_addr, cfg_wr_data (table_size, hash_modulus)
//
// Insert: accept, home-slot remainder (a second remainder when the home slot
// needs wrapping to table_size), one slot probed per cycle from registered
// RAM reads, then the result word.
// Full or zero-key rejects at accept go straight to the result. Clear sweeps all
// TABLE_DEPTH slots, one per cycle, then returns its word.
// After reset the same sweep runs over all TABLE_DEPTH slots with s_ready low.
// A finished word waits in the output register while the next one is accepted.
module linear_probe_hash_insert (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  lphi_pkg::in_word_t         s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output lphi_pkg::out_word_t        m_data,
    input  logic                       cfg_wr_en,
    input  logic                       cfg_addr,
    input  logic [lphi_pkg::CFG_W-1:0] cfg_wr_data
);
    import lphi_pkg::*;

    state_t               state_reg, state_next;
    logic [KEY_WIDTH-1:0] key_reg, key_next;
    logic [SLOT_W-1:0]    pos_reg, pos_next;
    logic [CFG_W-1:0]     steps_reg, steps_next;
    logic [CFG_W-1:0]     count_reg, count_next;
    out_word_t            res_reg, res_next;
    logic [SLOT_W-1:0]    sweep_addr_reg, sweep_addr_next;
    logic                 sweep_resp_reg, sweep_resp_next;
    logic                 m_valid_reg, m_valid_next;
    out_word_t            m_data_reg, m_data_next;
    logic [CFG_W-1:0]     size_reg;
    logic [CFG_W-1:0]     modulus_reg;

    logic [CFG_W-1:0]     eff_size;
    logic [CFG_W-1:0]     eff_mod;
    logic [CFG_W-1:0]     pos_inc;
    logic [SLOT_W-1:0]    pos_wrap;
    logic                 out_free;

    div_req_t             div_req;
    logic                 div_done;
    logic [CFG_W-1:0]     div_rem;
    ram_req_t             ram_req;
    logic [KEY_WIDTH-1:0] ram_rd_data;

    lphi_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req       (div_req),
        .done      (div_done),
        .remainder (div_rem)
    );

    lphi_ram u_ram (
        .aclk    (aclk),
        .req     (ram_req),
        .rd_data (ram_rd_data)
    );

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg    <= TABLE_SIZE_RST;
            modulus_reg <= HASH_MODULUS_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_TABLE_SIZE:   size_reg    <= cfg_wr_data;
                CFG_HASH_MODULUS: modulus_reg <= cfg_wr_data;
                default:          size_reg    <= size_reg;
            endcase
        end
    end

    always_comb begin
        if (size_reg == '0) begin
            eff_size = CFG_W'(1);
        end else if (size_reg > CFG_W'(TABLE_DEPTH)) begin
            eff_size = CFG_W'(TABLE_DEPTH);
        end else begin
            eff_size = size_reg;
        end
    end

    assign eff_mod  = (modulus_reg == '0) ? CFG_W'(1) : modulus_reg;
    assign pos_inc  = CFG_W'(pos_reg) + CFG_W'(1);
    assign pos_wrap = (pos_inc >= eff_size) ? '0 : pos_inc[SLOT_W-1:0];
    assign out_free = !m_valid_reg || m_ready;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_SWEEP;
            sweep_addr_reg <= '0;
            sweep_resp_reg <= 1'b0;
            count_reg      <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            sweep_addr_reg <= sweep_addr_next;
            sweep_resp_reg <= sweep_resp_next;
            count_reg      <= count_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg    <= key_next;
        pos_reg    <= pos_next;
        steps_reg  <= steps_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    always_comb begin
        state_next      = state_reg;
        key_next        = key_reg;
        pos_next        = pos_reg;
        steps_next      = steps_reg;
        count_next      = count_reg;
        res_next        = res_reg;
        sweep_addr_next = sweep_addr_reg;
        sweep_resp_next = sweep_resp_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;
        div_req         = '0;
        ram_req         = '0;

        unique case (state_reg)
            ST_SWEEP: begin
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = sweep_addr_reg;
                ram_req.wr_data = '0;
                sweep_addr_next = sweep_addr_reg + SLOT_W'(1);
                if (sweep_addr_reg == SLOT_W'(TABLE_DEPTH - 1)) begin
                    state_next      = sweep_resp_reg ? ST_RESP : ST_IDLE;
                    sweep_resp_next = 1'b0;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    key_next = s_data.key_value;
                    if (s_data.action == ACT_CLEAR) begin
                        count_next           = '0;
                        res_next.status      = STAT_CLEARED;
                        res_next.slot_index  = '0;
                        res_next.entry_count = '0;
                        sweep_addr_next      = '0;
                        sweep_resp_next      = 1'b1;
                        state_next           = ST_SWEEP;
                    end else if (count_reg >= eff_size) begin
                        res_next.status      = STAT_FULL;
                        res_next.slot_index  = '0;
                        res_next.entry_count = count_reg;
                        state_next           = ST_RESP;
                    end else if (s_data.key_value == '0) begin
                        res_next.status      = STAT_ZERO_KEY;
                        res_next.slot_index  = '0;
                        res_next.entry_count = count_reg;
                        state_next           = ST_RESP;
                    end else begin
                        div_req.start    = 1'b1;
                        div_req.dividend = DIV_W'(s_data.key_value);
                        div_req.divisor  = eff_mod;
                        div_req.chunks   = CHUNK_W'(HOME_CHUNKS);
                        state_next       = ST_DIV_HOME;
                    end
                end
            end
            ST_DIV_HOME: begin
                if (div_done) begin
                    if (div_rem < eff_size) begin
                        pos_next        = div_rem[SLOT_W-1:0];
                        steps_next      = '0;
                        ram_req.rd_en   = 1'b1;
                        ram_req.rd_addr = div_rem[SLOT_W-1:0];
                        state_next      = ST_PROBE;
                    end else begin
                        // home beyond table size: reduce modulo the size
                        div_req.start    = 1'b1;
                        div_req.dividend = DIV_W'(div_rem) << (DIV_W - WRAP_CHUNKS * DIV_STEP);
                        div_req.divisor  = eff_size;
                        div_req.chunks   = CHUNK_W'(WRAP_CHUNKS);
                        state_next       = ST_DIV_WRAP;
                    end
                end
            end
            ST_DIV_WRAP: begin
                if (div_done) begin
                    pos_next        = div_rem[SLOT_W-1:0];
                    steps_next      = '0;
                    ram_req.rd_en   = 1'b1;
                    ram_req.rd_addr = div_rem[SLOT_W-1:0];
                    state_next      = ST_PROBE;
                end
            end
            ST_PROBE: begin
                if (ram_rd_data == '0) begin
                    ram_req.wr_en        = 1'b1;
                    ram_req.wr_addr      = pos_reg;
                    ram_req.wr_data      = key_reg;
                    count_next           = count_reg + CFG_W'(1);
                    res_next.status      = STAT_INSERTED;
                    res_next.slot_index  = pos_reg;
                    res_next.entry_count = count_reg + CFG_W'(1);
                    state_next           = ST_RESP;
                end else if ((steps_reg + CFG_W'(1)) >= eff_size) begin
                    res_next.status      = STAT_FULL;
                    res_next.slot_index  = '0;
                    res_next.entry_count = count_reg;
                    state_next           = ST_RESP;
                end else begin
                    // advance to the next slot, wrapping at table size
                    pos_next        = pos_wrap;
                    steps_next      = steps_reg + CFG_W'(1);
                    ram_req.rd_en   = 1'b1;
                    ram_req.rd_addr = pos_wrap;
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CFG_W'(TABLE_DEPTH))
        else $error("stored count above table depth");

    a_probe_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_PROBE |-> CFG_W'(pos_reg) < eff_size)
        else $error("probe position outside table size");

    a_div_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DIV_HOME || state_reg == ST_DIV_WRAP))
        else $error("remainder finished outside a divide state");

    a_insert_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_req.wr_en && state_reg == ST_PROBE) |-> key_reg != '0)
        else $error("zero key written as a stored entry");

    a_resp_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RESP && out_free) |=> (m_valid && state_reg == ST_IDLE))
        else $error("finished word not loaded into output register");

endmodule
